// ===== rtl/fpre_pkg.sv =====
package fpre_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned DIM           = 3;

  localparam logic [1:0] REQ_SET     = 2'd0;
  localparam logic [1:0] REQ_COMPOSE = 2'd1;
  localparam logic [1:0] REQ_ROTATE  = 2'd2;
  localparam logic [1:0] REQ_RSVD    = 2'd3;

  localparam logic [1:0] AXIS_X     = 2'd0;
  localparam logic [1:0] AXIS_Y     = 2'd1;
  localparam logic [1:0] AXIS_Z     = 2'd2;
  localparam logic [1:0] AXIS_COUNT = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [1:0]         axis;
    logic signed [31:0] first_coord;
    logic signed [31:0] second_coord;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               degenerate;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQA,
    ST_SQB,
    ST_ROOT,
    ST_DIVS,
    ST_DIVC,
    ST_SETM,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    EL_ZERO,
    EL_ONE,
    EL_COS,
    EL_SIN,
    EL_NSIN
  } elem_e;

  // Entry kind of the elemental rotation about ax; the plane is the two axes after ax.
  function automatic elem_e elem_kind(logic [1:0] ax, logic [1:0] row, logic [1:0] col);
    logic [1:0] pi;
    logic [1:0] pj;
    elem_e      k;
    pi = (ax == AXIS_Z) ? AXIS_X : ax + 2'd1;
    pj = (pi == AXIS_Z) ? AXIS_X : pi + 2'd1;
    if ((row == pi && col == pi) || (row == pj && col == pj)) begin
      k = EL_COS;
    end else if (row == pi && col == pj) begin
      k = EL_SIN;
    end else if (row == pj && col == pi) begin
      k = EL_NSIN;
    end else if (row == col) begin
      k = EL_ONE;
    end else begin
      k = EL_ZERO;
    end
    return k;
  endfunction

endpackage

// ===== rtl/fixed_point_rotation_engine.sv =====
// Fixed-point 3-D rotation engine. Holds a 3x3 matrix (identity after reset) and takes one
// request at a time: build an elemental rotation that zeroes a coordinate (set or compose it
// into the matrix) or rotate a point. All arithmetic runs through one radix-2 shift-add
// multiplier, one bit-per-cycle square root and one bit-per-cycle restoring divider. Other
// request codes and an axis out of range go straight to the output. The next request is
// taken once the result sits in the output register.
module fixed_point_rotation_engine #(
  parameter int unsigned FRAC_BITS = fpre_pkg::FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = fpre_pkg::WORD_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  fpre_pkg::req_t in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fpre_pkg::rsp_t out_o
);

  localparam int unsigned W    = WORD_BITS;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned CntW = $clog2(W + F);
  localparam logic [63:0]  OneWide = 64'd1 << F;
  localparam logic [W-1:0] One     = OneWide[W-1:0];

  function automatic logic [W-1:0] mag(logic [W-1:0] x);
    return x[W-1] ? W'(~x + W'(1)) : x;
  endfunction

  function automatic logic [3:0] idx(logic [1:0] r, logic [1:0] c);
    return {2'b00, r} * 4'(fpre_pkg::DIM) + {2'b00, c};
  endfunction

  fpre_pkg::state_e state_q, state_d;
  fpre_pkg::req_t   req_q, req_d;
  fpre_pkg::rsp_t   out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [W-1:0]     m_q [9];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [W-1:0]     mcand_q, mcand_d;
  logic [2*W-1:0]   prod_q, prod_d;
  logic             neg_q, neg_d;
  logic [2*W-1:0]   sumsq_q, sumsq_d;
  logic [2*W-1:0]   rad_q, rad_d;
  logic [W+1:0]     rem_q, rem_d;
  logic [W-1:0]     root_q, root_d;
  logic [W+F-1:0]   dvd_q, dvd_d;
  logic [W-1:0]     drem_q, drem_d;
  logic [W-1:0]     s_q, s_d;
  logic [W-1:0]     c_q, c_d;
  logic             degen_q, degen_d;
  logic [W-1:0]     acc_q, acc_d;
  logic [W-1:0]     res_q [3];
  logic [W-1:0]     res_d [3];
  logic [1:0]       row_q, row_d, col_q, col_d, inr_q, inr_d;
  logic             set_all, row_wr;

  logic [W-1:0] a_w, b_w;
  assign a_w = req_q.first_coord[W-1:0];
  assign b_w = req_q.second_coord[W-1:0];

  function automatic logic [W-1:0] rval(fpre_pkg::elem_e k, logic [W-1:0] cv,
                                        logic [W-1:0] sv);
    logic [W-1:0] v;
    case (k)
      fpre_pkg::EL_ONE:  v = One;
      fpre_pkg::EL_COS:  v = cv;
      fpre_pkg::EL_SIN:  v = sv;
      fpre_pkg::EL_NSIN: v = W'(~sv + W'(1));
      default:           v = '0;
    endcase
    return v;
  endfunction

  function automatic fpre_pkg::elem_e kind_of(logic [1:0] ax, logic dg, logic [1:0] r,
                                              logic [1:0] c);
    fpre_pkg::elem_e k;
    if (dg) begin
      k = (r == c) ? fpre_pkg::EL_ONE : fpre_pkg::EL_ZERO;
    end else begin
      k = fpre_pkg::elem_kind(ax, r, c);
    end
    return k;
  endfunction

  // shift-add multiplier step
  logic [W:0]     mul_sum;
  logic [2*W-1:0] prod_step;
  assign mul_sum   = {1'b0, prod_q[2*W-1:W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
  assign prod_step = {mul_sum, prod_q[W-1:1]};

  // square root step
  logic [W+1:0] rem_sh, trial, root_rem;
  logic         root_ge;
  logic [W-1:0] root_nxt;
  assign rem_sh   = {rem_q[W-1:0], rad_q[2*W-1:2*W-2]};
  assign trial    = {root_q, 2'b01};
  assign root_ge  = rem_sh >= trial;
  assign root_rem = root_ge ? rem_sh - trial : rem_sh;
  assign root_nxt = {root_q[W-2:0], root_ge};

  // divider step
  logic [W:0]     drem_sh, dsub;
  logic           dge;
  logic [W-1:0]   div_rem;
  logic [W+F-1:0] div_dvd;
  logic [W-1:0]   quo, quo_neg;
  assign drem_sh = {drem_q, dvd_q[W+F-1]};
  assign dsub    = drem_sh - {1'b0, root_q};
  assign dge     = drem_sh >= {1'b0, root_q};
  assign div_rem = dge ? dsub[W-1:0] : drem_sh[W-1:0];
  assign div_dvd = {dvd_q[W+F-2:0], dge};
  assign quo     = div_dvd[W-1:0];
  assign quo_neg = W'(~quo + W'(1));

  // floor of signed product over 2^F, then accumulate
  logic [2*W+F-1:0] pext;
  logic [W-1:0]     pmid, term, acc_sum;
  logic             lowz;
  assign pext    = {{F{1'b0}}, prod_q};
  assign pmid    = pext[W+F-1:F];
  assign lowz    = (prod_q[F-1:0] == '0);
  assign term    = neg_q ? W'(~pmid + W'(lowz)) : pmid;
  assign acc_sum = acc_q + term;

  logic is_rot;
  assign is_rot = (req_q.req_type == fpre_pkg::REQ_ROTATE);

  logic [W-1:0] op_a, op_b;
  always_comb begin
    if (is_rot) begin
      op_a = m_q[idx(inr_q, col_q)];
      case (inr_q)
        2'd0:    op_b = req_q.point_x[W-1:0];
        2'd1:    op_b = req_q.point_y[W-1:0];
        default: op_b = req_q.point_z[W-1:0];
      endcase
    end else begin
      op_a = m_q[idx(row_q, inr_q)];
      op_b = rval(kind_of(req_q.axis, degen_q, inr_q, col_q), c_q, s_q);
    end
  end

  fpre_pkg::state_e post_r;
  assign post_r = (req_q.req_type == fpre_pkg::REQ_SET) ? fpre_pkg::ST_SETM : fpre_pkg::ST_LOAD;

  logic last_w, last_div;
  assign last_w   = (cnt_q == CntW'(W - 1));
  assign last_div = (cnt_q == CntW'(W + F - 1));

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    mcand_d     = mcand_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    sumsq_d     = sumsq_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    dvd_d       = dvd_q;
    drem_d      = drem_q;
    s_d         = s_q;
    c_d         = c_q;
    degen_d     = degen_q;
    acc_d       = acc_q;
    res_d       = res_q;
    row_d       = row_q;
    col_d       = col_q;
    inr_d       = inr_q;
    set_all     = 1'b0;
    row_wr      = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      fpre_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_i;
          degen_d  = 1'b0;
          res_d[0] = '0;
          res_d[1] = '0;
          res_d[2] = '0;
          acc_d    = '0;
          row_d    = '0;
          col_d    = '0;
          inr_d    = '0;
          cnt_d    = '0;
          mcand_d  = mag(in_i.first_coord[W-1:0]);
          prod_d   = {{W{1'b0}}, mag(in_i.first_coord[W-1:0])};
          if (in_i.req_type == fpre_pkg::REQ_ROTATE) begin
            state_d = fpre_pkg::ST_LOAD;
          end else if ((in_i.req_type == fpre_pkg::REQ_SET ||
                        in_i.req_type == fpre_pkg::REQ_COMPOSE) &&
                       in_i.axis < fpre_pkg::AXIS_COUNT) begin
            state_d = fpre_pkg::ST_SQA;
          end else begin
            state_d = fpre_pkg::ST_DONE;
          end
        end
      end
      fpre_pkg::ST_SQA: begin
        prod_d = prod_step;
        cnt_d  = cnt_q + 1'b1;
        if (last_w) begin
          sumsq_d = prod_step;
          mcand_d = mag(b_w);
          prod_d  = {{W{1'b0}}, mag(b_w)};
          cnt_d   = '0;
          state_d = fpre_pkg::ST_SQB;
        end
      end
      fpre_pkg::ST_SQB: begin
        prod_d = prod_step;
        cnt_d  = cnt_q + 1'b1;
        if (last_w) begin
          rad_d   = sumsq_q + prod_step;
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = fpre_pkg::ST_ROOT;
        end
      end
      fpre_pkg::ST_ROOT: begin
        rad_d  = {rad_q[2*W-3:0], 2'b00};
        rem_d  = root_rem;
        root_d = root_nxt;
        cnt_d  = cnt_q + 1'b1;
        if (last_w) begin
          cnt_d = '0;
          if (root_nxt == '0) begin
            degen_d = 1'b1;
            state_d = post_r;
          end else begin
            dvd_d   = {mag(a_w), {F{1'b0}}};
            drem_d  = '0;
            state_d = fpre_pkg::ST_DIVS;
          end
        end
      end
      fpre_pkg::ST_DIVS: begin
        dvd_d  = div_dvd;
        drem_d = div_rem;
        cnt_d  = cnt_q + 1'b1;
        if (last_div) begin
          s_d     = a_w[W-1] ? quo : quo_neg;
          dvd_d   = {mag(b_w), {F{1'b0}}};
          drem_d  = '0;
          cnt_d   = '0;
          state_d = fpre_pkg::ST_DIVC;
        end
      end
      fpre_pkg::ST_DIVC: begin
        dvd_d  = div_dvd;
        drem_d = div_rem;
        cnt_d  = cnt_q + 1'b1;
        if (last_div) begin
          c_d     = b_w[W-1] ? quo_neg : quo;
          cnt_d   = '0;
          state_d = post_r;
        end
      end
      fpre_pkg::ST_SETM: begin
        set_all = 1'b1;
        state_d = fpre_pkg::ST_DONE;
      end
      fpre_pkg::ST_LOAD: begin
        mcand_d = mag(op_a);
        prod_d  = {{W{1'b0}}, mag(op_b)};
        neg_d   = op_a[W-1] ^ op_b[W-1];
        cnt_d   = '0;
        state_d = fpre_pkg::ST_MUL;
      end
      fpre_pkg::ST_MUL: begin
        prod_d = prod_step;
        cnt_d  = cnt_q + 1'b1;
        if (last_w) begin
          state_d = fpre_pkg::ST_ACC;
        end
      end
      fpre_pkg::ST_ACC: begin
        acc_d   = acc_sum;
        state_d = fpre_pkg::ST_LOAD;
        if (inr_q == 2'd2) begin
          res_d[col_q] = acc_sum;
          acc_d        = '0;
          inr_d        = '0;
          if (col_q == 2'd2) begin
            col_d = '0;
            if (is_rot) begin
              state_d = fpre_pkg::ST_DONE;
            end else begin
              // write back the finished row
              row_wr = 1'b1;
              if (row_q == 2'd2) begin
                state_d = fpre_pkg::ST_DONE;
              end else begin
                row_d = row_q + 1'b1;
              end
            end
          end else begin
            col_d = col_q + 1'b1;
          end
        end else begin
          inr_d = inr_q + 1'b1;
        end
      end
      fpre_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          // only a point rotation reports coordinates
          out_valid_d      = 1'b1;
          out_d.out_x      = is_rot ? 32'($signed(res_q[0])) : '0;
          out_d.out_y      = is_rot ? 32'($signed(res_q[1])) : '0;
          out_d.out_z      = is_rot ? 32'($signed(res_q[2])) : '0;
          out_d.degenerate = degen_q;
          state_d          = fpre_pkg::ST_IDLE;
        end
      end
      default: state_d = fpre_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpre_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      for (int e = 0; e < 9; e++) begin
        m_q[e] <= (e % 4 == 0) ? One : '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (set_all) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            m_q[r * 3 + c] <= rval(kind_of(req_q.axis, degen_q, 2'(r), 2'(c)), c_q, s_q);
          end
        end
      end else if (row_wr) begin
        m_q[idx(row_q, 2'd0)] <= res_q[0];
        m_q[idx(row_q, 2'd1)] <= res_q[1];
        m_q[idx(row_q, 2'd2)] <= acc_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    out_q   <= out_d;
    cnt_q   <= cnt_d;
    mcand_q <= mcand_d;
    prod_q  <= prod_d;
    neg_q   <= neg_d;
    sumsq_q <= sumsq_d;
    rad_q   <= rad_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    dvd_q   <= dvd_d;
    drem_q  <= drem_d;
    s_q     <= s_d;
    c_q     <= c_d;
    degen_q <= degen_d;
    acc_q   <= acc_d;
    res_q   <= res_d;
    row_q   <= row_d;
    col_q   <= col_d;
    inr_q   <= inr_d;
  end

  assign in_stall_o  = (state_q != fpre_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
